### rtl/core/hbpi_pkg.sv
// Package for the hash bucket position index.
// Holds field widths, default sizes, function and error codes.
// No dependencies.
package hbpi_pkg;

    localparam int unsigned DefHashBuckets  = 4096;
    localparam int unsigned DefMaxPositions = 65536;

    localparam int unsigned FuncW  = 2;
    localparam int unsigned HashW  = 12;
    localparam int unsigned IndexW = 16;
    localparam int unsigned OffW   = 17;
    localparam int unsigned PosW   = 16;
    localparam int unsigned ErrW   = 2;

    typedef logic [FuncW-1:0] t_func;
    typedef logic [ErrW-1:0]  t_err;

    localparam t_func FUNC_INSERT   = 2'd0;
    localparam t_func FUNC_BUILD    = 2'd1;
    localparam t_func FUNC_BOUNDS   = 2'd2;
    localparam t_func FUNC_ENTRY    = 2'd3;

    localparam t_err  ERR_OK        = 2'd0;
    localparam t_err  ERR_RANGE     = 2'd1;
    localparam t_err  ERR_PHASE     = 2'd2;

endpackage

### rtl/core/hash_bucket_position_index.sv
// Hash bucket position index: top level, sequencer and storage.
// Depends on hbpi_pkg and hbpi_ram.
//
// Use: one input word per request on i_valid/o_stall (func, hash, index),
// one result word per request on o_valid/i_stall. Insert appends the next
// position to the chain of a bucket; build compacts all chains into one list
// with start offsets per bucket; the two reads return bucket bounds or a
// list entry. Every request gives exactly one result.
// A rejected request goes straight to the result; a bounds read of the last
// bucket takes its end from the position count, not from the head RAM.
// Build walks every bucket through the head RAM and each chain through the
// link RAM, position by position. One request is in work at a time; the
// next is taken once the result sits in the output register.
// Reset: after i_rst_n the head RAM is cleared one bucket a cycle, with
// o_stall high; count and build state return to zero. While i_stall holds a
// result, o_valid and the result fields hold and the block finishes its
// current request, then waits.
module hash_bucket_position_index
    import hbpi_pkg::*;
#(
    parameter int unsigned HASH_BUCKETS  = DefHashBuckets,
    parameter int unsigned MAX_POSITIONS = DefMaxPositions
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [FuncW-1:0]  i_func,
    input  logic [HashW-1:0]  i_hash,
    input  logic [IndexW-1:0] i_index,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [OffW-1:0]   o_start_res,
    output logic [OffW-1:0]   o_end_res,
    output logic [PosW-1:0]   o_position,
    output logic [OffW-1:0]   o_count,
    output logic [ErrW-1:0]   o_error
);

    localparam int unsigned BW = $clog2(HASH_BUCKETS);
    localparam int unsigned PW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int unsigned CW = $clog2(MAX_POSITIONS + 1);
    localparam logic [31:0]   HB32    = 32'(HASH_BUCKETS);
    localparam logic [CW-1:0] MAXC    = CW'(MAX_POSITIONS);
    localparam logic [BW-1:0] LAST_B  = BW'(HASH_BUCKETS - 1);

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_INS_RD  = 4'd2;
    localparam logic [3:0] S_INS_WR  = 4'd3;
    localparam logic [3:0] S_B_RD    = 4'd4;
    localparam logic [3:0] S_B_HEAD  = 4'd5;
    localparam logic [3:0] S_B_COPY  = 4'd6;
    localparam logic [3:0] S_B_LINK  = 4'd7;
    localparam logic [3:0] S_RB_RD   = 4'd8;
    localparam logic [3:0] S_RB_LO   = 4'd9;
    localparam logic [3:0] S_RB_HI   = 4'd10;
    localparam logic [3:0] S_RE_RD   = 4'd11;
    localparam logic [3:0] S_RE_DATA = 4'd12;
    localparam logic [3:0] S_OUT     = 4'd13;

    logic [3:0]    r_state, n_state;
    logic [BW-1:0] r_clr, n_clr;
    logic [BW-1:0] r_hash, n_hash;
    logic [PW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_total, n_total;
    logic          r_built, n_built;
    logic [BW-1:0] r_b, n_b;
    logic [CW-1:0] r_fill, n_fill;
    logic [PW-1:0] r_p, n_p;
    logic [PW-1:0] r_tail, n_tail;
    logic [OffW-1:0] r_res_start, n_res_start;
    logic [OffW-1:0] r_res_end, n_res_end;
    logic [PosW-1:0] r_res_pos, n_res_pos;
    t_err            r_res_err, n_res_err;
    logic            r_out_valid, n_out_valid;
    logic [OffW-1:0] r_out_start, r_out_end, r_out_count;
    logic [PosW-1:0] r_out_pos;
    t_err            r_out_err;
    logic            w_load;

    logic          head_we;
    logic [BW-1:0] head_waddr, head_raddr;
    logic [CW:0]   head_wdata, head_rdata;
    logic          tail_we;
    logic [BW-1:0] tail_waddr, tail_raddr;
    logic [PW-1:0] tail_wdata, tail_rdata;
    logic          link_we;
    logic [PW-1:0] link_waddr, link_raddr, link_wdata, link_rdata;
    logic          list_we;
    logic [PW-1:0] list_waddr, list_raddr, list_wdata, list_rdata;

    logic [31:0] w_hash32, w_idx32, w_total32, w_head32, w_pos32, w_list32, w_cur32;
    logic [CW-1:0] w_fill_inc;
    logic          w_last_b;

    assign w_hash32   = 32'(i_hash);
    assign w_idx32    = 32'(i_index);
    assign w_total32  = 32'(r_total);
    assign w_head32   = 32'(head_rdata[CW-1:0]);
    assign w_pos32    = 32'(r_total[PW-1:0]);
    assign w_list32   = 32'(list_rdata);
    assign w_cur32    = 32'(w_total32 + 32'd1);
    assign w_fill_inc = r_fill + CW'(1);
    assign w_last_b   = (r_b == LAST_B);

    hbpi_ram #(.WIDTH(CW + 1), .DEPTH(HASH_BUCKETS)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_raddr(head_raddr), .o_rdata(head_rdata)
    );

    hbpi_ram #(.WIDTH(PW), .DEPTH(HASH_BUCKETS)) u_tail (
        .i_clk(i_clk), .i_we(tail_we), .i_waddr(tail_waddr), .i_wdata(tail_wdata),
        .i_raddr(tail_raddr), .o_rdata(tail_rdata)
    );

    hbpi_ram #(.WIDTH(PW), .DEPTH(MAX_POSITIONS)) u_link (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_waddr), .i_wdata(link_wdata),
        .i_raddr(link_raddr), .o_rdata(link_rdata)
    );

    hbpi_ram #(.WIDTH(PW), .DEPTH(MAX_POSITIONS)) u_list (
        .i_clk(i_clk), .i_we(list_we), .i_waddr(list_waddr), .i_wdata(list_wdata),
        .i_raddr(list_raddr), .o_rdata(list_rdata)
    );

    assign o_stall = (r_state != S_IDLE);
    assign w_load  = (r_state == S_OUT) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_hash      = r_hash;
        n_idx       = r_idx;
        n_total     = r_total;
        n_built     = r_built;
        n_b         = r_b;
        n_fill      = r_fill;
        n_p         = r_p;
        n_tail      = r_tail;
        n_res_start = r_res_start;
        n_res_end   = r_res_end;
        n_res_pos   = r_res_pos;
        n_res_err   = r_res_err;

        head_we    = 1'b0;
        head_waddr = r_hash;
        head_wdata = '0;
        head_raddr = r_hash;
        tail_we    = 1'b0;
        tail_waddr = r_hash;
        tail_wdata = r_total[PW-1:0];
        tail_raddr = r_hash;
        link_we    = 1'b0;
        link_waddr = tail_rdata;
        link_wdata = r_total[PW-1:0];
        link_raddr = r_p;
        list_we    = 1'b0;
        list_waddr = r_fill[PW-1:0];
        list_wdata = r_p;
        list_raddr = r_idx;

        unique case (r_state)
            S_CLR: begin
                head_we    = 1'b1;
                head_waddr = r_clr;
                n_clr      = r_clr + BW'(1);
                if (r_clr == LAST_B) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_hash      = w_hash32[BW-1:0];
                    n_idx       = w_idx32[PW-1:0];
                    n_res_start = '0;
                    n_res_end   = '0;
                    n_res_pos   = '0;
                    n_res_err   = ERR_OK;
                    n_state     = S_OUT;
                    unique case (i_func)
                        FUNC_INSERT: begin
                            if (r_built) begin
                                n_res_err = ERR_PHASE;
                            end else if (r_total >= MAXC || w_hash32 >= HB32) begin
                                n_res_err = ERR_RANGE;
                            end else begin
                                n_state = S_INS_RD;
                            end
                        end
                        FUNC_BUILD: begin
                            if (r_built) begin
                                n_res_err = ERR_PHASE;
                            end else begin
                                n_b     = '0;
                                n_fill  = '0;
                                n_state = S_B_RD;
                            end
                        end
                        FUNC_BOUNDS: begin
                            if (!r_built) begin
                                n_res_err = ERR_PHASE;
                            end else if (w_hash32 >= HB32) begin
                                n_res_err = ERR_RANGE;
                            end else begin
                                n_state = S_RB_RD;
                            end
                        end
                        FUNC_ENTRY: begin
                            if (!r_built) begin
                                n_res_err = ERR_PHASE;
                            end else if (w_idx32 >= w_total32) begin
                                n_res_err = ERR_RANGE;
                            end else begin
                                n_state = S_RE_RD;
                            end
                        end
                        default: begin
                            n_res_err = ERR_PHASE;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                n_state = S_INS_WR;
            end
            S_INS_WR: begin
                if (head_rdata[CW]) begin
                    link_we = 1'b1;
                end else begin
                    head_we    = 1'b1;
                    head_wdata = {1'b1, CW'(r_total[PW-1:0])};
                end
                tail_we   = 1'b1;
                n_total   = w_cur32[CW-1:0];
                n_res_pos = w_pos32[PosW-1:0];
                n_state   = S_OUT;
            end
            S_B_RD: begin
                head_raddr = r_b;
                tail_raddr = r_b;
                n_state    = S_B_HEAD;
            end
            S_B_HEAD: begin
                head_we    = 1'b1;
                head_waddr = r_b;
                head_wdata = {1'b0, r_fill};
                if (head_rdata[CW]) begin
                    n_p     = head_rdata[PW-1:0];
                    n_tail  = tail_rdata;
                    n_state = S_B_COPY;
                end else if (w_last_b) begin
                    n_built = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_b     = r_b + BW'(1);
                    n_state = S_B_RD;
                end
            end
            S_B_COPY: begin
                list_we = (r_fill < MAXC);
                n_fill  = w_fill_inc;
                if (r_p == r_tail || w_fill_inc >= r_total) begin
                    if (w_last_b) begin
                        n_built = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_b     = r_b + BW'(1);
                        n_state = S_B_RD;
                    end
                end else begin
                    n_state = S_B_LINK;
                end
            end
            S_B_LINK: begin
                n_p     = link_rdata;
                n_state = S_B_COPY;
            end
            S_RB_RD: begin
                n_state = S_RB_LO;
            end
            S_RB_LO: begin
                n_res_start = w_head32[OffW-1:0];
                if (r_hash == LAST_B) begin
                    n_res_end = w_total32[OffW-1:0];
                    n_state   = S_OUT;
                end else begin
                    head_raddr = r_hash + BW'(1);
                    n_state    = S_RB_HI;
                end
            end
            S_RB_HI: begin
                n_res_end = w_head32[OffW-1:0];
                n_state   = S_OUT;
            end
            S_RE_RD: begin
                n_state = S_RE_DATA;
            end
            S_RE_DATA: begin
                n_res_pos = w_list32[PosW-1:0];
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_total     <= '0;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_total     <= n_total;
            r_built     <= n_built;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash      <= n_hash;
        r_idx       <= n_idx;
        r_b         <= n_b;
        r_fill      <= n_fill;
        r_p         <= n_p;
        r_tail      <= n_tail;
        r_res_start <= n_res_start;
        r_res_end   <= n_res_end;
        r_res_pos   <= n_res_pos;
        r_res_err   <= n_res_err;
        if (w_load) begin
            r_out_start <= r_res_start;
            r_out_end   <= r_res_end;
            r_out_pos   <= r_res_pos;
            r_out_count <= w_total32[OffW-1:0];
            r_out_err   <= r_res_err;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_start_res = r_out_start;
    assign o_end_res   = r_out_end;
    assign o_position  = r_out_pos;
    assign o_count     = r_out_count;
    assign o_error     = r_out_err;

endmodule

### rtl/core/hbpi_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module hbpi_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
